// ===== src/pbaa_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the per-thread bump arena allocator.
// No dependencies; imported by the core, the checker and the testbench.
package pbaa_pkg;

    localparam int OPCODE_W = 3;
    localparam int REQ_ID_W = 6;
    localparam int SIZE_W   = 32;
    localparam int ALIGN_W  = 5;
    localparam int ADDR_W   = 48;
    localparam int STATUS_W = 3;
    localparam int GEN_W    = 32;
    localparam int REQ_W    = 64;

    localparam logic [ALIGN_W-1:0] DEFAULT_ALIGN_LOG2 = 5'd4;

    localparam logic [OPCODE_W-1:0] OP_ALLOC       = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_ALLOC_ZERO  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_ALLOC_ALIGN = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_FREE_CHECK  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_PHASE       = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_DEACTIVATE  = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_SERVED      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FALLBACK    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FREE_IGNORE = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FREE_SYSTEM = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_ACK         = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_SLOT,
        ST_ALIGN,
        ST_CHECK,
        ST_FIN,
        ST_DONE
    } state_t;

endpackage

// ===== src/pbaa_slot_ram.sv =====
`timescale 1ns / 1ps
// Per-slot state memory: recorded generation and bump offset of each slab.
// One write port, one registered read port. Depends on nothing.
module pbaa_slot_ram #(
    parameter int DEPTH  = 16,
    parameter int AW     = 4,
    parameter int DATA_W = 65
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/per_thread_bump_arena_allocator_core.sv =====
`timescale 1ns / 1ps
// Per-thread bump arena allocator: one command in, one result out.
// Allocations walk map read, slot read, align, check and write back before the result
// waits for a free output register; other commands and early fallbacks go from map
// read straight to that output stage.
// One command is in flight at a time, set by the slot read-modify-write sequence;
// the next command is taken while the previous result waits at the output register.
// Synchronous active-low reset clears control state and all requester assignments.
module per_thread_bump_arena_allocator_core #(
    parameter int MAX_SLOTS       = 16,
    parameter int SLAB_BYTES_LOG2 = 32,
    parameter int REQUESTERS      = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [pbaa_pkg::ADDR_W-1:0]    cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [pbaa_pkg::OPCODE_W-1:0]  s_opcode,
    input  logic [pbaa_pkg::REQ_ID_W-1:0]  s_requester,
    input  logic [pbaa_pkg::SIZE_W-1:0]    s_size_bytes,
    input  logic [pbaa_pkg::SIZE_W-1:0]    s_elem_count,
    input  logic [pbaa_pkg::ALIGN_W-1:0]   s_align_log2,
    input  logic [pbaa_pkg::ADDR_W-1:0]    s_pointer,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [pbaa_pkg::STATUS_W-1:0]  m_status,
    output logic [pbaa_pkg::ADDR_W-1:0]    m_address,
    output logic                           m_zero_fill
);

    import pbaa_pkg::*;

    localparam int SLOT_AW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int SLOT_CW   = $clog2(MAX_SLOTS + 1);
    localparam int REQ_SPACE = 1 << REQ_ID_W;
    localparam int REQ_DEPTH = (REQUESTERS < REQ_SPACE) ? REQUESTERS : REQ_SPACE;
    localparam int REQ_AW    = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;
    localparam int OFF_W     = SLAB_BYTES_LOG2 + 1;
    localparam int SPAN_W    = SLOT_CW + SLAB_BYTES_LOG2;
    // two guard bits cover base + offset + alignment slack without wrap
    localparam int CALC_W    = ((SPAN_W > ADDR_W) ? SPAN_W : ADDR_W) + 2;
    localparam int ENTRY_W   = GEN_W + OFF_W;

    localparam logic [CALC_W-1:0] SLAB_LEN = CALC_W'(1) << SLAB_BYTES_LOG2;
    localparam logic [CALC_W-1:0] SPAN     = CALC_W'(MAX_SLOTS) << SLAB_BYTES_LOG2;

    state_t state_reg, state_next;

    // configuration and global control
    logic [ADDR_W-1:0]  region_reg;
    logic               armed_reg;
    logic               active_reg;
    logic [GEN_W-1:0]   gen_reg;
    logic [SLOT_CW-1:0] next_slot_reg;
    logic               req_valid_reg [REQ_DEPTH];
    logic [SLOT_AW-1:0] map_mem [REQ_DEPTH];
    logic [SLOT_AW-1:0] map_rd_reg;

    // captured command
    logic [OPCODE_W-1:0] op_reg;
    logic [REQ_ID_W-1:0] requester_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [SIZE_W-1:0]   count_reg;
    logic [ALIGN_W-1:0]  lg_reg;
    logic [ADDR_W-1:0]   ptr_reg;

    // allocation datapath
    logic [SLOT_AW-1:0] slot_reg;
    logic               fresh_reg;
    logic [REQ_W-1:0]   request_reg;
    logic [CALC_W-1:0]  base_reg;
    logic [OFF_W-1:0]   off_eff_reg;
    logic [CALC_W-1:0]  sum_reg;
    logic [CALC_W-1:0]  end_reg;
    logic [CALC_W-1:0]  a_reg;
    logic [CALC_W-1:0]  room_reg;
    logic [CALC_W-1:0]  arel_reg;
    logic               a_le_end_reg;

    // result and output registers
    logic [STATUS_W-1:0] res_status_reg;
    logic [ADDR_W-1:0]   res_addr_reg;
    logic                res_zero_reg;
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [ADDR_W-1:0]   m_address_reg;
    logic                m_zero_fill_reg;

    logic               accept;
    logic               out_load;
    logic               is_alloc;
    logic               in_range;
    logic [REQ_AW-1:0]  req_idx;
    logic               assigned;
    logic [SLOT_AW-1:0] slot_sel;
    logic               can_alloc;
    logic               ptr_in_region;
    logic [ADDR_W-1:0]  ptr_diff;
    logic [REQ_W-1:0]   request_calc;
    logic [CALC_W-1:0]  align_mask;
    logic [ENTRY_W-1:0] slot_rd_data;
    logic [GEN_W-1:0]   slot_rd_gen;
    logic [OFF_W-1:0]   slot_rd_off;
    logic               fits;
    logic [OFF_W-1:0]   new_off;
    logic               slot_wr_en;
    logic [ENTRY_W-1:0] slot_wr_data;

    assign accept  = s_valid && s_ready;
    assign req_idx = requester_reg[REQ_AW-1:0];

    assign is_alloc = (op_reg == OP_ALLOC) || (op_reg == OP_ALLOC_ZERO) ||
                      (op_reg == OP_ALLOC_ALIGN);
    assign in_range = (int'(requester_reg) < REQUESTERS);
    assign assigned = in_range && req_valid_reg[req_idx];
    assign slot_sel = assigned ? map_rd_reg : next_slot_reg[SLOT_AW-1:0];
    assign can_alloc = active_reg && (region_reg != '0) && in_range &&
                       (assigned || (next_slot_reg < SLOT_CW'(MAX_SLOTS)));

    assign ptr_diff      = ptr_reg - region_reg;
    assign ptr_in_region = (region_reg != '0) && (ptr_reg >= region_reg) &&
                           (CALC_W'(ptr_diff) < SPAN);

    assign request_calc = (op_reg == OP_ALLOC_ZERO) ? (size_reg * count_reg)
                                                    : REQ_W'(size_reg);
    assign align_mask   = (CALC_W'(1) << lg_reg) - CALC_W'(1);

    assign slot_rd_gen = slot_rd_data[ENTRY_W-1:OFF_W];
    assign slot_rd_off = slot_rd_data[OFF_W-1:0];

    assign fits    = a_le_end_reg && (request_reg <= REQ_W'(room_reg));
    assign new_off = arel_reg[OFF_W-1:0] + request_reg[OFF_W-1:0];

    // write back every reached slot: covers first assignment and rewind on fallback
    assign slot_wr_en   = (state_reg == ST_FIN);
    assign slot_wr_data = {gen_reg, (fits ? new_off : off_eff_reg)};

    pbaa_slot_ram #(
        .DEPTH  (MAX_SLOTS),
        .AW     (SLOT_AW),
        .DATA_W (ENTRY_W)
    ) u_slot_ram (
        .aclk    (aclk),
        .rd_en   (state_reg == ST_MAP),
        .rd_addr (slot_sel),
        .rd_data (slot_rd_data),
        .wr_en   (slot_wr_en),
        .wr_addr (slot_reg),
        .wr_data (slot_wr_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP: begin
                state_next = (is_alloc && can_alloc) ? ST_SLOT : ST_DONE;
            end
            ST_SLOT:  state_next = ST_ALIGN;
            ST_ALIGN: state_next = ST_CHECK;
            ST_CHECK: state_next = ST_FIN;
            ST_FIN:   state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_reg    <= '0;
            armed_reg     <= 1'b0;
            active_reg    <= 1'b0;
            gen_reg       <= '0;
            next_slot_reg <= '0;
            for (int i = 0; i < REQ_DEPTH; i++) begin
                req_valid_reg[i] <= 1'b0;
            end
        end else begin
            if (cfg_wr_en) begin
                region_reg <= cfg_wr_data;
            end
            if (state_reg == ST_MAP) begin
                if (op_reg == OP_PHASE) begin
                    if (!armed_reg) begin
                        armed_reg <= 1'b1;
                    end else begin
                        gen_reg    <= gen_reg + GEN_W'(1);
                        active_reg <= 1'b1;
                    end
                end else if (op_reg == OP_DEACTIVATE) begin
                    active_reg <= 1'b0;
                end
            end
            if (state_reg == ST_FIN && fresh_reg) begin
                req_valid_reg[req_idx] <= 1'b1;
                next_slot_reg          <= next_slot_reg + SLOT_CW'(1);
            end
        end
    end

    // requester-to-slot map
    always_ff @(posedge aclk) begin
        if (accept) begin
            map_rd_reg <= map_mem[s_requester[REQ_AW-1:0]];
        end
        if (state_reg == ST_FIN && fresh_reg) begin
            map_mem[req_idx] <= slot_reg;
        end
    end

    // command capture and placement datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg        <= s_opcode;
            requester_reg <= s_requester;
            size_reg      <= s_size_bytes;
            count_reg     <= s_elem_count;
            lg_reg        <= (s_opcode == OP_ALLOC_ALIGN) ? s_align_log2 : DEFAULT_ALIGN_LOG2;
            ptr_reg       <= s_pointer;
        end
        case (state_reg)
            ST_MAP: begin
                slot_reg       <= slot_sel;
                fresh_reg      <= !assigned;
                request_reg    <= request_calc;
                base_reg       <= CALC_W'(region_reg) + (CALC_W'(slot_sel) << SLAB_BYTES_LOG2);
                res_addr_reg   <= '0;
                res_zero_reg   <= 1'b0;
                if (is_alloc) begin
                    res_status_reg <= STAT_FALLBACK;
                end else if (op_reg == OP_FREE_CHECK) begin
                    res_status_reg <= ((ptr_reg == '0) || ptr_in_region) ? STAT_FREE_IGNORE
                                                                         : STAT_FREE_SYSTEM;
                end else begin
                    res_status_reg <= STAT_ACK;
                end
            end
            ST_SLOT: begin
                // rewind a fresh or stale slot to the slab start
                if (fresh_reg || (slot_rd_gen != gen_reg)) begin
                    off_eff_reg <= '0;
                    sum_reg     <= base_reg;
                end else begin
                    off_eff_reg <= slot_rd_off;
                    sum_reg     <= base_reg + CALC_W'(slot_rd_off);
                end
                end_reg <= base_reg + SLAB_LEN;
            end
            ST_ALIGN: begin
                a_reg <= (sum_reg + align_mask) & ~align_mask;
            end
            ST_CHECK: begin
                a_le_end_reg <= (a_reg <= end_reg);
                room_reg     <= end_reg - a_reg;
                arel_reg     <= a_reg - base_reg;
            end
            ST_FIN: begin
                if (fits) begin
                    res_status_reg <= STAT_SERVED;
                    res_addr_reg   <= a_reg[ADDR_W-1:0];
                    res_zero_reg   <= (op_reg == OP_ALLOC_ZERO);
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg    <= res_status_reg;
            m_address_reg   <= res_addr_reg;
            m_zero_fill_reg <= res_zero_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_address   = m_address_reg;
    assign m_zero_fill = m_zero_fill_reg;

endmodule

// ===== src/pbaa_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the bump arena allocator core, bound to the top level.
// Depends on pbaa_pkg for field widths and status codes.
module pbaa_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [pbaa_pkg::STATUS_W-1:0]  m_status,
    input logic [pbaa_pkg::ADDR_W-1:0]    m_address,
    input logic                           m_zero_fill
);

    import pbaa_pkg::*;

    // a stalled result transfer holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status) && $stable(m_address) &&
                                   $stable(m_zero_fill)))
        else $error("result changed while stalled");

    // one command in flight: no input transfer right after another
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a command is in flight");

    // only served results carry an address or a zero-fill flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STAT_SERVED)) |-> ((m_address == '0) && !m_zero_fill))
        else $error("address or zero fill on a non-served result");

    // status codes stay within the defined set
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STAT_SERVED || m_status == STAT_FALLBACK ||
                     m_status == STAT_FREE_IGNORE || m_status == STAT_FREE_SYSTEM ||
                     m_status == STAT_ACK))
        else $error("undefined status code");

endmodule

bind per_thread_bump_arena_allocator_core pbaa_checker u_pbaa_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_address   (m_address),
    .m_zero_fill (m_zero_fill)
);

// ===== test/per_thread_bump_arena_allocator_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for per_thread_bump_arena_allocator_core: directed table, then
// random command streams checked against a built-in arena predictor. Depends on pbaa_pkg.
module per_thread_bump_arena_allocator_core_test;
    import pbaa_pkg::*;

    localparam int NUM_SLOTS  = 16;
    localparam int SLAB_LOG2  = 32;
    localparam int NUM_REQ    = 64;
    localparam int LIMIT      = 200000;
    localparam int PARK_LEN   = 60;

    localparam logic [OPCODE_W-1:0] OP_RSVD_A = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_RSVD_B = 3'd7;

    localparam logic [ADDR_W-1:0] DIR_BASE = 48'h0100_0000_0000;
    localparam logic [ADDR_W-1:0] BASE_TOP = 48'hFFEF_FFFF_FFFF;
    localparam logic [ADDR_W-1:0] SPAN     = 48'h0010_0000_0000;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [REQ_ID_W-1:0] who;
        logic [SIZE_W-1:0]   size;
        logic [SIZE_W-1:0]   count;
        logic [ALIGN_W-1:0]  lg;
        logic [ADDR_W-1:0]   ptr;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
        logic                zf;
    } res_t;

    typedef struct packed {
        cmd_t cmd;
        bit   typed;
        res_t want;
    } row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_wr_en;
    logic [ADDR_W-1:0]   cfg_wr_data;
    logic                s_valid;
    logic                s_ready;
    logic [OPCODE_W-1:0] s_opcode;
    logic [REQ_ID_W-1:0] s_requester;
    logic [SIZE_W-1:0]   s_size_bytes;
    logic [SIZE_W-1:0]   s_elem_count;
    logic [ALIGN_W-1:0]  s_align_log2;
    logic [ADDR_W-1:0]   s_pointer;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;
    logic [ADDR_W-1:0]   m_address;
    logic                m_zero_fill;

    // Side tags that travel with the payload: typed expectation for directed rows.
    bit   tag_typed;
    res_t tag_want;

    int unsigned     errors = 0;
    int unsigned     cycles = 0;
    int unsigned     sent = 0;
    int unsigned     finished = 0;
    bit              quiet = 1'b0;
    bit              park_rx = 1'b0;
    logic [ADDR_W-1:0] cur_base = '0;

    // Arena predictor state
    logic [ADDR_W-1:0] region_q;
    bit                armed_q;
    bit                live_q;
    logic [GEN_W-1:0]  epoch;
    int unsigned       next_free_slot;
    bit                has_slot [NUM_REQ];
    int unsigned       slot_of [NUM_REQ];
    logic [SLAB_LOG2:0] bump_off [NUM_SLOTS];
    logic [GEN_W-1:0]  slot_epoch [NUM_SLOTS];

    res_t owed [$];

    per_thread_bump_arena_allocator_core #(
        .MAX_SLOTS       (NUM_SLOTS),
        .SLAB_BYTES_LOG2 (SLAB_LOG2),
        .REQUESTERS      (NUM_REQ)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_requester  (s_requester),
        .s_size_bytes (s_size_bytes),
        .s_elem_count (s_elem_count),
        .s_align_log2 (s_align_log2),
        .s_pointer    (s_pointer),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_address    (m_address),
        .m_zero_fill  (m_zero_fill)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic void clear_arena();
        region_q       = '0;
        armed_q        = 1'b0;
        live_q         = 1'b0;
        epoch          = '0;
        next_free_slot = 0;
        for (int i = 0; i < NUM_REQ; i++) begin
            has_slot[i] = 1'b0;
            slot_of[i]  = 0;
        end
    endfunction

    // Bump-allocate from the requester's slab; claims a slot on first use.
    function automatic res_t bump(input int unsigned who, input logic [63:0] request,
                                  input int unsigned lg, input bit zeroed);
        logic [63:0] slab_lo, slab_hi, mask, spot;
        int unsigned s;
        res_t r;
        r = '0;
        r.status = STAT_FALLBACK;
        if (!live_q || region_q == '0) return r;
        if (!has_slot[who]) begin
            if (next_free_slot >= NUM_SLOTS) return r;
            has_slot[who] = 1'b1;
            slot_of[who]  = next_free_slot;
            bump_off[next_free_slot]   = '0;
            slot_epoch[next_free_slot] = epoch;
            next_free_slot++;
        end
        s = slot_of[who];
        // rewind stays even if this request falls back
        if (slot_epoch[s] != epoch) begin
            bump_off[s]   = '0;
            slot_epoch[s] = epoch;
        end
        slab_lo = 64'(region_q) + (64'(s) << SLAB_LOG2);
        slab_hi = slab_lo + (64'd1 << SLAB_LOG2);
        mask    = (64'd1 << lg) - 64'd1;
        spot    = (slab_lo + 64'(bump_off[s]) + mask) & ~mask;
        if (spot > slab_hi || request > slab_hi - spot) return r;
        bump_off[s] = (SLAB_LOG2+1)'(spot + request - slab_lo);
        r.status = STAT_SERVED;
        r.addr   = spot[ADDR_W-1:0];
        r.zf     = zeroed;
        return r;
    endfunction

    function automatic res_t predict(input cmd_t c);
        res_t r;
        r = '0;
        r.status = STAT_ACK;
        case (c.op)
            OP_ALLOC:       r = bump(c.who, 64'(c.size), DEFAULT_ALIGN_LOG2, 1'b0);
            OP_ALLOC_ZERO:  r = bump(c.who, 64'(c.size) * 64'(c.count), DEFAULT_ALIGN_LOG2, 1'b1);
            OP_ALLOC_ALIGN: r = bump(c.who, 64'(c.size), c.lg, 1'b0);
            OP_FREE_CHECK: begin
                if (c.ptr == '0 || (region_q != '0 && c.ptr >= region_q &&
                    64'(c.ptr) - 64'(region_q) < (64'(NUM_SLOTS) << SLAB_LOG2)))
                    r.status = STAT_FREE_IGNORE;
                else
                    r.status = STAT_FREE_SYSTEM;
            end
            OP_PHASE: begin
                if (!armed_q) begin
                    armed_q = 1'b1;
                end else begin
                    epoch  = epoch + 1'b1;
                    live_q = 1'b1;
                end
            end
            OP_DEACTIVATE: live_q = 1'b0;
            default: ;
        endcase
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        errors++;
        $display("MISMATCH %s: got 'h%0h want 'h%0h (result %0d)", what, got, want,
                 finished);
    endtask

    always @(posedge aclk) begin : monitor
        cmd_t seen;
        res_t got;
        res_t head;
        if (!aresetn) begin
            clear_arena();
        end else begin
            if (cfg_wr_en) region_q = cfg_wr_data;
            if (s_valid && s_ready) begin
                seen.op    = s_opcode;
                seen.who   = s_requester;
                seen.size  = s_size_bytes;
                seen.count = s_elem_count;
                seen.lg    = s_align_log2;
                seen.ptr   = s_pointer;
                got = predict(seen);
                owed.push_back(tag_typed ? tag_want : got);
            end
            if (m_valid && m_ready) begin
                if (owed.size() == 0) begin
                    note_mismatch("result with nothing pending, status", 64'(m_status), 64'd0);
                end else begin
                    head = owed.pop_front();
                    if (m_status !== head.status)
                        note_mismatch("status", 64'(m_status), 64'(head.status));
                    if (m_address !== head.addr)
                        note_mismatch("address", 64'(m_address), 64'(head.addr));
                    if (m_zero_fill !== head.zf)
                        note_mismatch("zero_fill", 64'(m_zero_fill), 64'(head.zf));
                    finished++;
                end
            end
        end
    end

    // Result side: random stall bursts, plus one long park on request.
    initial begin : sink
        int unsigned n;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (park_rx) begin
                m_ready <= 1'b0;
                repeat (PARK_LEN) @(posedge aclk);
                park_rx = 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 6);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic offer(input cmd_t c, input bit typed, input res_t want);
        s_valid      <= 1'b1;
        s_opcode     <= c.op;
        s_requester  <= c.who;
        s_size_bytes <= c.size;
        s_elem_count <= c.count;
        s_align_log2 <= c.lg;
        s_pointer    <= c.ptr;
        tag_typed    <= typed;
        tag_want     <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    endtask

    // Hold the input until every transfer so far has its result back.
    task automatic drain();
        s_valid <= 1'b0;
        while (finished != sent) @(posedge aclk);
    endtask

    task automatic write_base(input logic [ADDR_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        cur_base     = v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic row_t mk(input logic [OPCODE_W-1:0] op, input logic [REQ_ID_W-1:0] who,
                                input logic [SIZE_W-1:0] size, input logic [SIZE_W-1:0] count,
                                input logic [ALIGN_W-1:0] lg, input logic [ADDR_W-1:0] ptr,
                                input bit typed = 1'b0,
                                input logic [STATUS_W-1:0] st = STAT_SERVED,
                                input logic [ADDR_W-1:0] addr = '0, input bit zf = 1'b0);
        row_t r;
        r.cmd.op = op;
        r.cmd.who = who;
        r.cmd.size = size;
        r.cmd.count = count;
        r.cmd.lg = lg;
        r.cmd.ptr = ptr;
        r.typed = typed;
        r.want.status = st;
        r.want.addr = addr;
        r.want.zf = zf;
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'($urandom());
            2: return 32'hFFFF_FFFF;
            3, 4: return 32'($urandom_range(32'h0010_0000, 32'h1000_0000));
            default: return 32'($urandom_range(1, 512));
        endcase
    endfunction

    task automatic run_random(input int unsigned items, input bit park);
        cmd_t c;
        res_t none;
        int unsigned pick;
        none = '0;
        for (int unsigned k = 0; k < items; k++) begin
            if (park && k == 30) park_rx = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 28)      c.op = OP_ALLOC;
            else if (pick < 46) c.op = OP_ALLOC_ZERO;
            else if (pick < 66) c.op = OP_ALLOC_ALIGN;
            else if (pick < 80) c.op = OP_FREE_CHECK;
            else if (pick < 88) c.op = OP_PHASE;
            else if (pick < 92) c.op = OP_DEACTIVATE;
            else if (pick < 96) c.op = OP_RSVD_A;
            else                c.op = OP_RSVD_B;
            c.who   = REQ_ID_W'($urandom_range(0, NUM_REQ - 1));
            c.size  = pick_size();
            c.count = ($urandom_range(0, 3) == 0) ? 32'($urandom()) : 32'($urandom_range(0, 8));
            c.lg    = ALIGN_W'($urandom());
            c.ptr   = {16'($urandom()), 32'($urandom())};
            if (c.op == OP_FREE_CHECK) begin
                case ($urandom_range(0, 6))
                    0: c.ptr = '0;
                    1: c.ptr = cur_base;
                    2: c.ptr = cur_base + SPAN - 1'b1;
                    3: c.ptr = cur_base + SPAN;
                    4: c.ptr = cur_base - 1'b1;
                    5: c.ptr = cur_base + ADDR_W'({4'($urandom()), 32'($urandom())});
                    default: ;
                endcase
            end
            offer(c, 1'b0, none);
        end
    endtask

    initial begin : stimulus
        row_t plan [$];
        int unsigned base_row;
        aresetn      <= 1'b0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        s_valid      <= 1'b0;
        s_opcode     <= OP_ALLOC;
        s_requester  <= '0;
        s_size_bytes <= '0;
        s_elem_count <= '0;
        s_align_log2 <= '0;
        s_pointer    <= '0;
        tag_typed    <= 1'b0;
        tag_want     <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // No region yet, then arm and activate.
        plan.push_back(mk(OP_ALLOC, 0, 16, 0, 0, '0, 1, STAT_FALLBACK));
        plan.push_back(mk(OP_FREE_CHECK, 0, 0, 0, 0, '0, 1, STAT_FREE_IGNORE));
        plan.push_back(mk(OP_FREE_CHECK, 63, 0, 0, 0, '1, 1, STAT_FREE_SYSTEM));
        plan.push_back(mk(OP_PHASE, 0, 0, 0, 0, '0, 1, STAT_ACK));
        plan.push_back(mk(OP_ALLOC, 7, 64, 0, 0, '0, 1, STAT_FALLBACK));
        plan.push_back(mk(OP_PHASE, 0, 0, 0, 0, '0, 1, STAT_ACK));
        plan.push_back(mk(OP_ALLOC_ZERO, 5, 1, 1, 0, '0, 1, STAT_FALLBACK));
        plan.push_back(mk(OP_RSVD_A, 63, '1, '1, '1, '1, 1, STAT_ACK));
        plan.push_back(mk(OP_RSVD_B, 0, 0, 0, 0, '0, 1, STAT_ACK));
        base_row = plan.size();
        // Region present: first slot, extremes of size, count and alignment.
        plan.push_back(mk(OP_ALLOC, 63, 0, 0, 0, '0, 1, STAT_SERVED, DIR_BASE, 0));
        plan.push_back(mk(OP_ALLOC_ZERO, 63, 3, 5, 0, '0));
        plan.push_back(mk(OP_ALLOC_ALIGN, 63, 1, 0, 31, '0));
        plan.push_back(mk(OP_ALLOC, 0, '1, 0, 0, '0));
        plan.push_back(mk(OP_ALLOC_ZERO, 1, '1, '1, 0, '0, 1, STAT_FALLBACK));
        plan.push_back(mk(OP_ALLOC_ZERO, 2, 0, '1, 0, '0));
        plan.push_back(mk(OP_ALLOC_ALIGN, 3, 32'h8000_0000, 0, 0, '0));
        plan.push_back(mk(OP_ALLOC_ALIGN, 3, 32'h8000_0001, 0, 5, '0));
        plan.push_back(mk(OP_FREE_CHECK, 0, 0, 0, 0, DIR_BASE, 1, STAT_FREE_IGNORE));
        plan.push_back(mk(OP_FREE_CHECK, 0, 0, 0, 0, DIR_BASE + SPAN - 1'b1, 1,
                          STAT_FREE_IGNORE));
        plan.push_back(mk(OP_FREE_CHECK, 0, 0, 0, 0, DIR_BASE + SPAN, 1, STAT_FREE_SYSTEM));
        plan.push_back(mk(OP_FREE_CHECK, 0, 0, 0, 0, DIR_BASE - 1'b1, 1, STAT_FREE_SYSTEM));
        plan.push_back(mk(OP_DEACTIVATE, 0, 0, 0, 0, '0, 1, STAT_ACK));
        plan.push_back(mk(OP_ALLOC, 63, 16, 0, 0, '0, 1, STAT_FALLBACK));
        plan.push_back(mk(OP_PHASE, 0, 0, 0, 0, '0, 1, STAT_ACK));
        // new generation: offset rewinds to the slab start
        plan.push_back(mk(OP_ALLOC, 63, 16, 0, 0, '0));

        foreach (plan[i]) begin
            if (i == base_row) begin
                drain();
                write_base(DIR_BASE);
            end
            offer(plan[i].cmd, plan[i].typed, plan[i].want);
        end

        drain();
        write_base(BASE_TOP);
        run_random(140, 1'b1);

        drain();
        write_base({16'($urandom_range(0, 16'hFFEF)), 32'($urandom())} | 48'd1);
        run_random(140, 1'b0);

        drain();
        write_base('0);
        run_random(60, 1'b0);

        drain();
        write_base({16'($urandom_range(0, 16'h00FF)), 32'($urandom()) & 32'hFFFF_F000}
                   | 48'h1000);
        quiet = 1'b1;
        run_random(140, 1'b0);

        drain();
        repeat (20) @(posedge aclk);
        if (errors == 0 && owed.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/pbaa_pkg.sv
src/pbaa_slot_ram.sv
src/per_thread_bump_arena_allocator_core.sv
src/pbaa_checker.sv
test/per_thread_bump_arena_allocator_core_test.sv
